FILE: rtl/core/lfvs_pkg.sv
package lfvs_pkg;

  // defaults for the top-level parameters
  localparam int unsigned FRAME_COUNT_DEF = 16;
  localparam int unsigned AGE_BITS_DEF    = 16;

  // fixed widths of the request and result payloads
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned FRAME_W      = 4;
  localparam int unsigned VICTIM_AGE_W = 16;

  // event codes carried in the request
  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGN    = 2'd0,
    KIND_TOUCH     = 2'd1,
    KIND_MARK_BUSY = 2'd2,
    KIND_MARK_FREE = 2'd3
  } kind_e;

  // per-entry control handed from the sequencer to the age unit
  typedef struct packed {
    logic  apply;      // request frame lies within the frame table
    kind_e kind;       // event being processed
    logic  is_target;  // current entry is the frame named by the request
    logic  busy;       // current entry is marked in use
  } lfvs_op_t;

endpackage

FILE: rtl/core/lfvs_req_if.sv
interface lfvs_req_if import lfvs_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [FRAME_W-1:0] frame;

  modport source (output valid, output kind, output frame, input ready);
  modport sink   (input valid, input kind, input frame, output ready);

endinterface

FILE: rtl/core/lfvs_rsp_if.sv
interface lfvs_rsp_if import lfvs_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [FRAME_W-1:0]      victim_frame;
  logic [VICTIM_AGE_W-1:0] victim_age;

  modport source (output valid, output victim_frame, output victim_age, input ready);
  modport sink   (input valid, input victim_frame, input victim_age, output ready);

endinterface

FILE: rtl/core/lfvs_age_mem.sv
module lfvs_age_mem import lfvs_pkg::*; #(
  parameter  int unsigned Depth = FRAME_COUNT_DEF,
  parameter  int unsigned Width = AGE_BITS_DEF,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rd_data_q;
  logic             rd_vld_q;

  // storage array, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
      rd_vld_q  <= vld_q[rd_addr_i];
    end
  end

  // written flags, cleared by reset so unwritten entries read as zero age
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: rtl/core/lfvs_age_unit.sv
module lfvs_age_unit import lfvs_pkg::*; #(
  parameter int unsigned AgeW = AGE_BITS_DEF
) (
  input  lfvs_op_t        op_i,
  input  logic [AgeW-1:0] age_i,
  input  logic [AgeW-1:0] best_age_i,
  output logic [AgeW-1:0] age_o,
  output logic            take_o
);

  logic clear;
  logic bump;

  // decide whether the entry is cleared, aged or left alone
  always_comb begin
    clear = 1'b0;
    bump  = 1'b0;
    case (op_i.kind) inside
      KIND_ASSIGN: begin
        clear = op_i.apply & op_i.is_target;
      end
      KIND_TOUCH: begin
        clear = op_i.apply & op_i.is_target;
        bump  = op_i.apply & ~op_i.is_target & ~op_i.busy & (age_i != '1);
      end
      KIND_MARK_BUSY, KIND_MARK_FREE: begin
        clear = 1'b0;
      end
      default: begin
        clear = 1'b0;
      end
    endcase
  end

  // saturating increment and running maximum compare, ties to the later entry
  always_comb begin
    if (clear) begin
      age_o = '0;
    end else if (bump) begin
      age_o = age_i + AgeW'(1);
    end else begin
      age_o = age_i;
    end
    take_o = (age_o >= best_age_i);
  end

endmodule

FILE: rtl/core/lru_frame_victim_selector.sv
// channel   modport  payload                                handshake
// req_i     sink     kind[1:0], frame[3:0]                  valid / ready
// rsp_o     source   victim_frame[3:0], victim_age[15:0]    valid / ready
//
// a request runs from acceptance to a valid result as one pass over the age memory
// through its single read port and the shared update and compare unit, followed by
// the load of the result register
// req_i.ready is high only while the sequencer is idle; a request may be taken
// while the previous result still waits in the result register
// a stalled result holds the sequencer before it loads the next one
// after reset all ages read as zero and no frame is in use; no clearing pass
module lru_frame_victim_selector import lfvs_pkg::*; #(
  parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int unsigned AGE_BITS    = AGE_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  lfvs_req_if.sink   req_i,
  lfvs_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(FRAME_COUNT);
  localparam int unsigned CntW = $clog2(FRAME_COUNT + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DONE  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         idx_q, idx_d;
  logic                    rd_vld_q;
  logic [IdxW-1:0]         rd_idx_q;
  kind_e                   kind_q;
  logic [IdxW-1:0]         frame_q;
  logic                    apply_q;
  logic [FRAME_COUNT-1:0]  busy_q;
  logic [AGE_BITS-1:0]     best_age_q;
  logic [IdxW-1:0]         best_idx_q;
  logic                    rsp_vld_q;
  logic [FRAME_W-1:0]      rsp_frame_q;
  logic [VICTIM_AGE_W-1:0] rsp_age_q;

  logic                    req_fire;
  logic                    req_in_range;
  logic [IdxW-1:0]         req_idx;
  logic                    rd_en;
  logic [IdxW-1:0]         rd_addr;
  logic                    last_entry;
  logic                    rsp_load;
  logic [AGE_BITS-1:0]     age_rd;
  logic [AGE_BITS-1:0]     age_new;
  logic                    take;
  lfvs_op_t                op;

  // request decode
  assign req_i.ready  = (state_q == ST_IDLE);
  assign req_fire     = req_i.valid & req_i.ready;
  assign req_in_range = (32'(req_i.frame) < 32'(FRAME_COUNT));
  assign req_idx      = IdxW'(req_i.frame);

  // sweep control
  assign rd_en      = (state_q == ST_SWEEP) && (idx_q < CntW'(FRAME_COUNT));
  assign rd_addr    = idx_q[IdxW-1:0];
  assign last_entry = rd_vld_q && (rd_idx_q == IdxW'(FRAME_COUNT - 1));
  assign rsp_load   = (state_q == ST_DONE) && (!rsp_vld_q || rsp_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_SWEEP;
          idx_d   = '0;
        end
      end
      ST_SWEEP: begin
        if (rd_en) begin
          idx_d = idx_q + CntW'(1);
        end
        if (last_entry) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_en;
    end
  end

  // in-use flags, updated as the request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (req_fire && req_in_range) begin
      unique case (kind_e'(req_i.kind)) inside
        KIND_MARK_BUSY: busy_q[req_idx] <= 1'b1;
        KIND_ASSIGN,
        KIND_MARK_FREE: busy_q[req_idx] <= 1'b0;
        default:        busy_q[req_idx] <= busy_q[req_idx];
      endcase
    end
  end

  // request capture, entry index in flight and running best
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q     <= kind_e'(req_i.kind);
      frame_q    <= req_idx;
      apply_q    <= req_in_range;
      best_age_q <= '0;
      best_idx_q <= '0;
    end else if (rd_vld_q && take) begin
      best_age_q <= age_new;
      best_idx_q <= rd_idx_q;
    end
    if (rd_en) begin
      rd_idx_q <= rd_addr;
    end
  end

  // age storage
  lfvs_age_mem #(
    .Depth (FRAME_COUNT),
    .Width (AGE_BITS)
  ) u_age_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (age_rd),
    .wr_en_i   (rd_vld_q),
    .wr_addr_i (rd_idx_q),
    .wr_data_i (age_new)
  );

  // shared update and compare unit
  always_comb begin
    op.apply     = apply_q;
    op.kind      = kind_q;
    op.is_target = (rd_idx_q == frame_q);
    op.busy      = busy_q[rd_idx_q];
  end

  lfvs_age_unit #(
    .AgeW (AGE_BITS)
  ) u_age_unit (
    .op_i       (op),
    .age_i      (age_rd),
    .best_age_i (best_age_q),
    .age_o      (age_new),
    .take_o     (take)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_frame_q <= FRAME_W'(best_idx_q);
      rsp_age_q   <= VICTIM_AGE_W'(best_age_q);
    end
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.victim_frame = rsp_frame_q;
  assign rsp_o.victim_age   = rsp_age_q;

  // checks
  a_rd_only_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SWEEP))
    else $error("memory read data in flight outside the sweep");

  a_sweep_starts_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == ST_SWEEP) && (idx_q == '0))
    else $error("sweep did not start at entry zero");

  a_idx_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CntW'(FRAME_COUNT))
    else $error("sweep index ran past the frame table");

  a_load_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |=> rsp_vld_q && (state_q == ST_IDLE))
    else $error("result load did not raise valid or return to idle");

endmodule
